[rtl/c8_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package c8_pkg;
  localparam int RamBytes     = 4096;
  localparam int StackDepth   = 16;
  localparam int ScreenWidth  = 64;
  localparam int ScreenHeight = 32;

  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_EXEC = 2'd1;
  localparam logic [1:0] OP_TICK = 2'd2;
  localparam logic [1:0] OP_READ = 2'd3;

  localparam logic [11:0] PC_RESET = 12'h200;

  // width of a packed input transaction: 2+12+8+16+1+4+8+5 = 56
  localparam int InDataW  = 56;
  // output: 12+64+1+1+1+1+1 = 81 -> 88
  localparam int OutDataW = 88;
endpackage
`default_nettype wire

[rtl/chip8_instruction_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// CHIP-8 core driven by stream transactions: load a RAM byte, execute one instruction at PC,
// tick the delay and sound timers, or read one framebuffer row. Each input transaction yields
// one result transaction, and the input is not ready again until that result has been taken.
// A small sequencer steps one shared byte datapath over the single-port RAM. Load, tick and
// read go straight to the result; a plain instruction takes two RAM reads for the fetch, then
// decode, execute and result; DRW adds a read, a shift and an XOR step per sprite row, Fx55
// one write per register, Fx65 a read and a load step per register, Fx33 one subtraction per
// cycle for the digits, CLS one framebuffer row per cycle. After reset a pass over all 32
// framebuffer rows clears them before the first input is taken.
module chip8_instruction_core #(
  parameter int STACK_DEPTH = c8_pkg::StackDepth
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  // opcode, load_address, load_byte, keys_down, key_press_valid, key_press_code,
  // random_byte, display_row
  input  wire logic [c8_pkg::InDataW-1:0]  in_tdata,
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  // program_counter, row_pixels, waiting_for_key, sound_active, display_changed,
  // unknown_instruction, stack_overflow, zero fill
  output logic [c8_pkg::OutDataW-1:0]      out_tdata
);
  localparam int SpW = $clog2(STACK_DEPTH);
  localparam int ScW = $clog2(STACK_DEPTH + 1);

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_FET0  = 4'd2;
  localparam logic [3:0] S_FET1  = 4'd3;
  localparam logic [3:0] S_DEC   = 4'd4;
  localparam logic [3:0] S_CLS   = 4'd5;
  localparam logic [3:0] S_DRWA  = 4'd6;
  localparam logic [3:0] S_DRWB  = 4'd7;
  localparam logic [3:0] S_DRWC  = 4'd8;
  localparam logic [3:0] S_STR   = 4'd9;
  localparam logic [3:0] S_LDA   = 4'd10;
  localparam logic [3:0] S_LDB   = 4'd11;
  localparam logic [3:0] S_BCD   = 4'd12;
  localparam logic [3:0] S_OUT   = 4'd13;
  localparam logic [3:0] S_RET   = 4'd14;

  logic [7:0]  ram [0:c8_pkg::RamBytes-1];
  logic [11:0] stk [0:STACK_DEPTH-1];
  logic [63:0] fb  [0:c8_pkg::ScreenHeight-1];
  logic [7:0]  v_r [0:15];

  logic [3:0]  state_r;
  // keys_down, key_press_valid, key_press_code, random_byte of the current transaction
  logic [28:0] in_r;
  logic [11:0] pc_r;
  logic [15:0] i_r;
  logic [ScW-1:0] sc_r;
  logic [7:0]  dt_r, st_r;
  logic [15:0] w_r;
  logic [7:0]  rd_r;
  logic [4:0]  cnt_r;
  logic [63:0] row_r, spr_r;
  logic        hit_r, ch_r, unk_r, wait_r, ovf_r;
  logic [7:0]  bcd_r;
  logic [1:0]  bphase_r;
  logic [11:0] ret_r;
  logic        out_valid_r;
  logic [80:0] out_r;

  // ram port: one address, one write per cycle
  logic [11:0] ra;
  logic        rwe;
  logic [7:0]  rwd;

  logic [15:0] i_keys;
  logic        i_kpv;
  logic [3:0]  i_kpc;
  logic [7:0]  i_rnd;
  assign i_keys = in_r[15:0];
  assign i_kpv  = in_r[16];
  assign i_kpc  = in_r[20:17];
  assign i_rnd  = in_r[28:21];

  logic [3:0]  wx, wy, wn;
  logic [7:0]  kk, vx, vy;
  logic [11:0] nnn, nxt, skp;
  assign wx  = w_r[11:8];
  assign wy  = w_r[7:4];
  assign wn  = w_r[3:0];
  assign kk  = w_r[7:0];
  assign nnn = w_r[11:0];
  assign vx  = v_r[wx];
  assign vy  = v_r[wy];
  assign nxt = pc_r + 12'd2;
  assign skp = pc_r + 12'd4;

  always_comb begin
    ra = pc_r;
    rwe = 1'b0;
    rwd = 8'd0;
    case (state_r)
      S_IDLE: begin
        ra = in_tdata[13:2];
        rwe = in_tvalid && in_tready && (in_tdata[1:0] == c8_pkg::OP_LOAD);
        rwd = in_tdata[21:14];
      end
      S_FET0: ra = pc_r;
      S_FET1: ra = pc_r + 12'd1;
      S_DRWA, S_LDA: ra = i_r[11:0] + {7'd0, cnt_r};
      S_STR: begin
        ra = i_r[11:0] + {7'd0, cnt_r};
        rwe = 1'b1;
        rwd = v_r[cnt_r[3:0]];
      end
      S_BCD: begin
        ra = i_r[11:0] + {10'd0, bphase_r};
        rwe = 1'b1;
        rwd = bcd_r;
      end
      default: ra = pc_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rwe) ram[ra] <= rwd;
    rd_r <= ram[ra];
  end

  logic [7:0] sum;
  logic       carry;
  assign {carry, sum} = {1'b0, vx} + {1'b0, vy};

  assign in_tready  = (state_r == S_IDLE) && !out_valid_r;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_r};

  logic [5:0] cx;
  assign cx = vx[5:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      cnt_r       <= 5'd0;
      pc_r        <= c8_pkg::PC_RESET;
      i_r         <= 16'd0;
      sc_r        <= '0;
      dt_r        <= 8'd0;
      st_r        <= 8'd0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < 16; k++) v_r[k] <= 8'd0;
    end else begin
      if (out_valid_r && out_tready) out_valid_r <= 1'b0;
      case (state_r)
        S_CLR: begin
          fb[cnt_r] <= 64'd0;
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'd31) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (in_tvalid && in_tready) begin
            in_r <= in_tdata[50:22];
            hit_r <= 1'b0; ch_r <= 1'b0; unk_r <= 1'b0; wait_r <= 1'b0; ovf_r <= 1'b0;
            row_r <= 64'd0;
            cnt_r <= 5'd0;
            case (in_tdata[1:0])
              c8_pkg::OP_EXEC: state_r <= S_FET0;
              c8_pkg::OP_TICK: begin
                if (dt_r != 8'd0) dt_r <= dt_r - 8'd1;
                if (st_r != 8'd0) st_r <= st_r - 8'd1;
                state_r <= S_OUT;
              end
              c8_pkg::OP_READ: begin
                row_r <= fb[in_tdata[55:51]];
                state_r <= S_OUT;
              end
              default: state_r <= S_OUT;
            endcase
          end
        end
        S_FET0: state_r <= S_FET1;
        S_FET1: begin
          w_r[15:8] <= rd_r;
          state_r <= S_DEC;
        end
        S_DEC: begin
          w_r[7:0] <= rd_r;
          state_r <= S_RET;
        end
        S_RET: begin
          // execute decoded word
          state_r <= S_OUT;
          case (w_r[15:12])
            4'h0: begin
              if (w_r == 16'h00E0) begin
                cnt_r <= 5'd0;
                state_r <= S_CLS;
                pc_r <= nxt;
              end else if (w_r == 16'h00EE) begin
                if (sc_r != '0) begin
                  sc_r <= sc_r - 1'b1;
                  pc_r <= stk[SpW'(sc_r - 1'b1)];
                end
              end else pc_r <= nxt;
            end
            4'h1: pc_r <= nnn;
            4'h2: begin
              if (sc_r >= ScW'(STACK_DEPTH)) begin
                ovf_r <= 1'b1;
                pc_r <= nxt;
              end else begin
                stk[SpW'(sc_r)] <= nxt;
                sc_r <= sc_r + 1'b1;
                pc_r <= nnn;
              end
            end
            4'h3: pc_r <= (vx == kk) ? skp : nxt;
            4'h4: pc_r <= (vx != kk) ? skp : nxt;
            4'h5: pc_r <= (vx == vy) ? skp : nxt;
            4'h6: begin v_r[wx] <= kk; pc_r <= nxt; end
            4'h7: begin v_r[wx] <= vx + kk; pc_r <= nxt; end
            4'h8: begin
              pc_r <= nxt;
              case (wn)
                4'h0: v_r[wx] <= vy;
                4'h1: v_r[wx] <= vx | vy;
                4'h2: v_r[wx] <= vx & vy;
                4'h3: v_r[wx] <= vx ^ vy;
                4'h4: begin v_r[wx] <= sum; v_r[15] <= {7'd0, carry}; end
                4'h5: begin v_r[wx] <= vx - vy; v_r[15] <= {7'd0, vx >= vy}; end
                4'h6: begin v_r[wx] <= {1'b0, vx[7:1]}; v_r[15] <= {7'd0, vx[0]}; end
                4'h7: begin v_r[wx] <= vy - vx; v_r[15] <= {7'd0, vy >= vx}; end
                4'hE: begin v_r[wx] <= {vx[6:0], 1'b0}; v_r[15] <= {7'd0, vx[7]}; end
                default: begin unk_r <= 1'b1; pc_r <= pc_r; end
              endcase
            end
            4'h9: pc_r <= (vx != vy) ? skp : nxt;
            4'hA: begin i_r <= {4'd0, nnn}; pc_r <= nxt; end
            4'hB: pc_r <= nnn + {4'd0, v_r[0]};
            4'hC: begin v_r[wx] <= i_rnd & kk; pc_r <= nxt; end
            4'hD: begin
              pc_r <= nxt;
              cnt_r <= 5'd0;
              if (wn == 4'd0) v_r[15] <= 8'd0;
              else state_r <= S_DRWA;
            end
            4'hE: begin
              if (kk == 8'h9E) pc_r <= (vx < 8'd16 && i_keys[vx[3:0]]) ? skp : nxt;
              else if (kk == 8'hA1) pc_r <= (vx < 8'd16 && i_keys[vx[3:0]]) ? nxt : skp;
              else unk_r <= 1'b1;
            end
            default: begin
              case (kk)
                8'h07: begin v_r[wx] <= dt_r; pc_r <= nxt; end
                8'h0A: begin
                  if (i_kpv) begin v_r[wx] <= {4'd0, i_kpc}; pc_r <= nxt; end
                  else wait_r <= 1'b1;
                end
                8'h15: begin dt_r <= vx; pc_r <= nxt; end
                8'h18: begin st_r <= vx; pc_r <= nxt; end
                8'h1E: begin i_r <= i_r + {8'd0, vx}; pc_r <= nxt; end
                8'h29: begin i_r <= {8'd0, vx} * 16'd5; pc_r <= nxt; end
                8'h33: begin
                  // digits by repeated subtraction on the shared byte unit
                  bcd_r <= 8'd0; ret_r <= {4'd0, vx}; bphase_r <= 2'd0;
                  cnt_r <= 5'd0; state_r <= S_DRWB; pc_r <= nxt;
                end
                8'h55: begin cnt_r <= 5'd0; state_r <= S_STR; pc_r <= nxt; end
                8'h65: begin cnt_r <= 5'd0; state_r <= S_LDA; pc_r <= nxt; end
                default: unk_r <= 1'b1;
              endcase
            end
          endcase
        end
        S_CLS: begin
          if (fb[cnt_r] != 64'd0) ch_r <= 1'b1;
          fb[cnt_r] <= 64'd0;
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'd31) state_r <= S_OUT;
        end
        S_DRWA: begin
          if (w_r[15:12] == 4'hD) state_r <= S_DRWC;
          else state_r <= S_OUT;
        end
        S_DRWC: begin
          spr_r <= ({rd_r, 56'd0} >> cx) | ({rd_r, 56'd0} << (7'd64 - {1'b0, cx}));
          state_r <= S_DRWB;
        end
        S_DRWB: begin
          if (w_r[15:12] == 4'hD) begin
            if ((fb[vy[4:0] + cnt_r] & spr_r) != 64'd0) hit_r <= 1'b1;
            if (spr_r != 64'd0) ch_r <= 1'b1;
            fb[vy[4:0] + cnt_r] <= fb[vy[4:0] + cnt_r] ^ spr_r;
            if (cnt_r + 5'd1 == {1'b0, wn}) begin
              v_r[15] <= {7'd0, hit_r || ((fb[vy[4:0] + cnt_r] & spr_r) != 64'd0)};
              state_r <= S_OUT;
            end else begin
              cnt_r <= cnt_r + 5'd1;
              state_r <= S_DRWA;
            end
          end else begin
            // bcd digit extraction: subtract 100 or 10 until below
            if (bphase_r == 2'd2) begin
              bcd_r <= ret_r[7:0];
              state_r <= S_BCD;
            end else if (ret_r[7:0] >= (bphase_r == 2'd0 ? 8'd100 : 8'd10)) begin
              ret_r <= ret_r - (bphase_r == 2'd0 ? 12'd100 : 12'd10);
              bcd_r <= bcd_r + 8'd1;
            end else state_r <= S_BCD;
          end
        end
        S_BCD: begin
          bcd_r <= 8'd0;
          if (bphase_r == 2'd2) state_r <= S_OUT;
          else begin
            bphase_r <= bphase_r + 2'd1;
            state_r <= S_DRWB;
          end
        end
        S_STR: begin
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r[3:0] == wx) state_r <= S_OUT;
        end
        S_LDA: state_r <= S_LDB;
        S_LDB: begin
          v_r[cnt_r[3:0]] <= rd_r;
          cnt_r <= cnt_r + 5'd1;
          state_r <= (cnt_r[3:0] == wx) ? S_OUT : S_LDA;
        end
        S_OUT: begin
          out_r <= {ovf_r, unk_r, ch_r, st_r != 8'd0, wait_r, row_r, pc_r};
          out_valid_r <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

[rtl/c8_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
module c8_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_tvalid,
  input wire logic                        in_tready,
  input wire logic                        out_tvalid,
  input wire logic                        out_tready,
  input wire logic [c8_pkg::OutDataW-1:0] out_tdata
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped while stalled");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("accepted two items back to back");
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("input ready with result pending");
  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[87:81] == 7'd0)
    else $error("nonzero fill bits");
endmodule
bind chip8_instruction_core c8_checker u_chk (.*);
`default_nettype wire

[bench/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;
  typedef struct packed {
    logic [1:0]  op;
    logic [11:0] addr;
    logic [7:0]  data;
    logic [15:0] keys;
    logic        key_vld;
    logic [3:0]  key_code;
    logic [7:0]  rnd;
    logic [4:0]  row;
  } stim_t;

  // laid out as on out_tdata, program counter in the lowest bits
  typedef struct packed {
    logic        overflow;
    logic        unknown;
    logic        changed;
    logic        sound;
    logic        wait_key;
    logic [63:0] pixels;
    logic [11:0] pc;
  } core_res_t;

  typedef struct {
    logic [1:0]  op;
    logic [15:0] word;
    logic        key_vld;
    logic [3:0]  key_code;
    logic        typed;
    core_res_t   res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [c8_pkg::InDataW-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [c8_pkg::OutDataW-1:0] out_tdata;

  chip8_instruction_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always #4 clk = ~clk;

  // shadow copy of the core state
  logic [7:0]  mem_bytes [c8_pkg::RamBytes];
  bit          mem_known [c8_pkg::RamBytes];
  logic [63:0] fb_rows [c8_pkg::ScreenHeight];
  logic [7:0]  vreg [16];
  logic [15:0] idx;
  logic [11:0] pc;
  logic [11:0] ret_stack [c8_pkg::StackDepth];
  int          sp_cnt;
  logic [7:0]  dly;
  logic [7:0]  snd;

  core_res_t results_due[$];
  dir_row_t  dir_rows[$];
  int        mismatches = 0;
  int        idle_cycles = 0;
  int        stall_left = 0;
  bit        quiet = 0;

  function automatic logic [c8_pkg::InDataW-1:0] pack_stim(stim_t s);
    return {s.row, s.rnd, s.key_code, s.key_vld, s.keys, s.data, s.addr, s.op};
  endfunction

  function automatic void mem_put(logic [11:0] a, logic [7:0] v);
    mem_bytes[a] = v;
    mem_known[a] = 1;
  endfunction

  function automatic void exec_instr(stim_t s, ref core_res_t r);
    logic [15:0] w;
    logic [3:0]  x, y, n;
    logic [7:0]  kk, vx, vy, res8;
    logic [11:0] nnn, nxt, skp, a;
    logic [63:0] spr;
    logic        flag, has_flag, unk, hit, ch, down;
    int          cx, cy;
    w = {mem_bytes[pc], mem_bytes[pc + 12'd1]};
    x = w[11:8]; y = w[7:4]; n = w[3:0]; kk = w[7:0]; nnn = w[11:0];
    vx = vreg[x]; vy = vreg[y];
    nxt = pc + 12'd2; skp = pc + 12'd4;
    unk = 0;
    case (w[15:12])
      4'h0: begin
        if (w == 16'h00E0) begin
          ch = 0;
          for (int i = 0; i < c8_pkg::ScreenHeight; i++) begin
            if (fb_rows[i] != 0) ch = 1;
            fb_rows[i] = '0;
          end
          r.changed = ch;
          pc = nxt;
        end else if (w == 16'h00EE) begin
          if (sp_cnt > 0) begin
            sp_cnt--;
            pc = ret_stack[sp_cnt];
          end
        end else pc = nxt;
      end
      4'h1: pc = nnn;
      4'h2: begin
        if (sp_cnt >= c8_pkg::StackDepth) begin
          r.overflow = 1;
          pc = nxt;
        end else begin
          ret_stack[sp_cnt] = nxt;
          sp_cnt++;
          pc = nnn;
        end
      end
      4'h3: pc = (vx == kk) ? skp : nxt;
      4'h4: pc = (vx != kk) ? skp : nxt;
      4'h5: pc = (vx == vy) ? skp : nxt;
      4'h6: begin vreg[x] = kk; pc = nxt; end
      4'h7: begin vreg[x] = vx + kk; pc = nxt; end
      4'h8: begin
        has_flag = 1; flag = 0; res8 = '0;
        case (n)
          4'h0: begin res8 = vy; has_flag = 0; end
          4'h1: begin res8 = vx | vy; has_flag = 0; end
          4'h2: begin res8 = vx & vy; has_flag = 0; end
          4'h3: begin res8 = vx ^ vy; has_flag = 0; end
          4'h4: begin {flag, res8} = {1'b0, vx} + {1'b0, vy}; end
          4'h5: begin res8 = vx - vy; flag = vx >= vy; end
          4'h6: begin res8 = vx >> 1; flag = vx[0]; end
          4'h7: begin res8 = vy - vx; flag = vy >= vx; end
          4'hE: begin res8 = vx << 1; flag = vx[7]; end
          default: unk = 1;
        endcase
        if (!unk) begin
          vreg[x] = res8;
          if (has_flag) vreg[15] = {7'd0, flag};
          pc = nxt;
        end
      end
      4'h9: pc = (vx != vy) ? skp : nxt;
      4'hA: begin idx = {4'd0, nnn}; pc = nxt; end
      4'hB: pc = nnn + {4'd0, vreg[0]};
      4'hC: begin vreg[x] = s.rnd & kk; pc = nxt; end
      4'hD: begin
        cx = vx % 64; cy = vy % 32; hit = 0; ch = 0;
        for (int i = 0; i < n; i++) begin
          a = idx[11:0] + 12'(i);
          spr = {mem_bytes[a], 56'd0};
          spr = (spr >> cx) | (spr << (64 - cx));
          if ((fb_rows[(cy + i) % 32] & spr) != 0) hit = 1;
          if (spr != 0) ch = 1;
          fb_rows[(cy + i) % 32] ^= spr;
        end
        vreg[15] = {7'd0, hit};
        r.changed = ch;
        pc = nxt;
      end
      4'hE: begin
        down = (vx < 16) && s.keys[vx[3:0]];
        if (kk == 8'h9E) pc = down ? skp : nxt;
        else if (kk == 8'hA1) pc = down ? nxt : skp;
        else unk = 1;
      end
      default: begin
        case (kk)
          8'h07: begin vreg[x] = dly; pc = nxt; end
          8'h0A: begin
            if (s.key_vld) begin
              vreg[x] = {4'd0, s.key_code};
              pc = nxt;
            end else r.wait_key = 1;
          end
          8'h15: begin dly = vx; pc = nxt; end
          8'h18: begin snd = vx; pc = nxt; end
          8'h1E: begin idx = idx + {8'd0, vx}; pc = nxt; end
          8'h29: begin idx = vx * 16'd5; pc = nxt; end
          8'h33: begin
            mem_put(idx[11:0], vx / 100);
            mem_put(idx[11:0] + 12'd1, (vx / 10) % 10);
            mem_put(idx[11:0] + 12'd2, vx % 10);
            pc = nxt;
          end
          8'h55: begin
            for (int i = 0; i <= x; i++) mem_put(idx[11:0] + 12'(i), vreg[i]);
            pc = nxt;
          end
          8'h65: begin
            for (int i = 0; i <= x; i++) vreg[i] = mem_bytes[idx[11:0] + 12'(i)];
            pc = nxt;
          end
          default: unk = 1;
        endcase
      end
    endcase
    r.unknown = unk;
  endfunction

  function automatic core_res_t core_step(stim_t s);
    core_res_t r;
    r = '0;
    case (s.op)
      c8_pkg::OP_LOAD: mem_put(s.addr, s.data);
      c8_pkg::OP_EXEC: exec_instr(s, r);
      c8_pkg::OP_TICK: begin
        if (dly != 0) dly--;
        if (snd != 0) snd--;
      end
      default: r.pixels = fb_rows[s.row];
    endcase
    r.pc = pc;
    r.sound = snd != 0;
    return r;
  endfunction

  function automatic stim_t rand_stim(logic [1:0] op);
    stim_t s;
    s.op = op;
    s.addr = 12'($urandom_range(0, 4095));
    s.data = 8'($urandom_range(0, 255));
    s.keys = 16'($urandom_range(0, 65535));
    s.key_vld = 1'($urandom_range(0, 1));
    s.key_code = 4'($urandom_range(0, 15));
    s.rnd = 8'($urandom_range(0, 255));
    s.row = 5'($urandom_range(0, 31));
    return s;
  endfunction

  function automatic logic [15:0] rand_word();
    logic [3:0] cls;
    logic [15:0] w;
    logic [7:0] f_ops [9] = '{8'h07, 8'h0A, 8'h15, 8'h18, 8'h1E, 8'h29, 8'h33, 8'h55, 8'h65};
    logic [3:0] alu_ops [9] = '{4'h0, 4'h1, 4'h2, 4'h3, 4'h4, 4'h5, 4'h6, 4'h7, 4'hE};
    cls = 4'($urandom_range(0, 15));
    w = {cls, 12'($urandom_range(0, 4095))};
    case (cls)
      4'h0: case ($urandom_range(0, 3))
        0: w = 16'h00E0;
        1, 2: w = 16'h00EE;
        default: ;
      endcase
      4'h8: if ($urandom_range(0, 7) != 0) w[3:0] = alu_ops[$urandom_range(0, 8)];
      4'hE: case ($urandom_range(0, 4))
        0, 1: w[7:0] = 8'h9E;
        2, 3: w[7:0] = 8'hA1;
        default: ;
      endcase
      4'hF: if ($urandom_range(0, 9) != 0) w[7:0] = f_ops[$urandom_range(0, 8)];
      default: ;
    endcase
    return w;
  endfunction

  task automatic send(stim_t s, bit typed = 0, core_res_t typed_res = '0);
    core_res_t r;
    int gap;
    r = core_step(s);
    results_due.insert(results_due.size(), typed ? typed_res : r);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 13);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tdata <= pack_stim(s);
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
  endtask

  // writes the word at pc and any never-written bytes the instruction reads, then runs it
  task automatic run_word(logic [15:0] w, stim_t ex, bit typed = 0, core_res_t typed_res = '0);
    stim_t ld;
    int cnt;
    cnt = 0;
    if (w[15:12] == 4'hD) cnt = w[3:0];
    else if (w[15:12] == 4'hF && w[7:0] == 8'h65) cnt = w[11:8] + 1;
    for (int i = 0; i < cnt; i++) begin
      if (!mem_known[idx[11:0] + 12'(i)]) begin
        ld = rand_stim(c8_pkg::OP_LOAD);
        ld.addr = idx[11:0] + 12'(i);
        send(ld);
      end
    end
    ld = rand_stim(c8_pkg::OP_LOAD);
    ld.addr = pc; ld.data = w[15:8];
    send(ld);
    ld = rand_stim(c8_pkg::OP_LOAD);
    ld.addr = pc + 12'd1; ld.data = w[7:0];
    send(ld);
    ex.op = c8_pkg::OP_EXEC;
    send(ex, typed, typed_res);
  endtask

  function automatic void add_row(logic [1:0] op, logic [15:0] w, logic kv, bit typed,
                                  logic [11:0] epc = '0, logic [4:0] eflags = '0);
    dir_row_t d;
    d.op = op; d.word = w; d.key_vld = kv; d.key_code = 4'hF; d.typed = typed;
    d.res = '0;
    d.res.pc = epc;
    {d.res.wait_key, d.res.sound, d.res.changed, d.res.unknown, d.res.overflow} = eflags;
    dir_rows.insert(dir_rows.size(), d);
  endfunction

  // receiver with random stall bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(0, 12);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // result check and watchdog
  always @(posedge clk) begin
    core_res_t got, want;
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (out_tvalid && out_tready) begin
        got = out_tdata[80:0];
        if (results_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected transaction: %h", got);
        end else begin
          want = results_due.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: pc %h/%h pixels %h/%h flags %b/%b (expected/actual)",
                       want.pc, got.pc, want.pixels, got.pixels, want[80:76], got[80:76]);
          end
        end
      end
      if (idle_cycles > 3000) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    stim_t s;
    int sent, pick;
    for (int i = 0; i < c8_pkg::RamBytes; i++) begin mem_bytes[i] = '0; mem_known[i] = 0; end
    for (int i = 0; i < c8_pkg::ScreenHeight; i++) fb_rows[i] = '0;
    for (int i = 0; i < 16; i++) vreg[i] = '0;
    idx = '0; pc = c8_pkg::PC_RESET; sp_cnt = 0; dly = '0; snd = '0;

    add_row(c8_pkg::OP_READ, 16'h0000, 0, 1, 12'h200, 5'b00000);
    add_row(c8_pkg::OP_TICK, 16'h0000, 0, 1, 12'h200, 5'b00000);
    add_row(c8_pkg::OP_EXEC, 16'h6AFF, 0, 1, 12'h202, 5'b00000);
    add_row(c8_pkg::OP_EXEC, 16'h00E0, 0, 1, 12'h204, 5'b00000);
    add_row(c8_pkg::OP_EXEC, 16'h00EE, 0, 1, 12'h204, 5'b00000);
    add_row(c8_pkg::OP_EXEC, 16'h0123, 0, 1, 12'h206, 5'b00000);
    add_row(c8_pkg::OP_EXEC, 16'hF00A, 0, 1, 12'h206, 5'b10000);
    add_row(c8_pkg::OP_EXEC, 16'hF00A, 1, 1, 12'h208, 5'b00000);
    add_row(c8_pkg::OP_EXEC, 16'h8AB8, 0, 1, 12'h208, 5'b00010);
    add_row(c8_pkg::OP_EXEC, 16'hE0FF, 0, 1, 12'h208, 5'b00010);
    add_row(c8_pkg::OP_EXEC, 16'hF0FF, 0, 1, 12'h208, 5'b00010);
    add_row(c8_pkg::OP_EXEC, 16'hEA9E, 0, 0);
    add_row(c8_pkg::OP_EXEC, 16'hAFFF, 0, 0);
    add_row(c8_pkg::OP_EXEC, 16'hDAAF, 0, 0);
    add_row(c8_pkg::OP_READ, 16'h0000, 0, 0);
    add_row(c8_pkg::OP_EXEC, 16'hD000, 0, 0);
    add_row(c8_pkg::OP_EXEC, 16'h8AF4, 0, 0);
    add_row(c8_pkg::OP_EXEC, 16'h8FA5, 0, 0);
    add_row(c8_pkg::OP_EXEC, 16'h8A07, 0, 0);
    add_row(c8_pkg::OP_EXEC, 16'h8AFE, 0, 0);
    add_row(c8_pkg::OP_EXEC, 16'hFA1E, 0, 0);
    add_row(c8_pkg::OP_EXEC, 16'hFA33, 0, 0);
    add_row(c8_pkg::OP_EXEC, 16'hFF55, 0, 0);
    add_row(c8_pkg::OP_EXEC, 16'hFA18, 0, 0);
    add_row(c8_pkg::OP_EXEC, 16'h1FFE, 0, 0);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      s = rand_stim(dir_rows[i].op);
      s.key_vld = dir_rows[i].key_vld;
      s.key_code = dir_rows[i].key_code;
      if (dir_rows[i].op == c8_pkg::OP_EXEC) run_word(dir_rows[i].word, s, dir_rows[i].typed,
                                                       dir_rows[i].res);
      else send(s, dir_rows[i].typed, dir_rows[i].res);
    end

    // drain completely before the random traffic
    in_tvalid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);

    sent = 0;
    while (sent < 1250) begin
      if (sent > 1100) quiet = 1;
      pick = $urandom_range(0, 99);
      if (pick < 10) begin send(rand_stim(c8_pkg::OP_TICK)); sent++; end
      else if (pick < 18) begin send(rand_stim(c8_pkg::OP_READ)); sent++; end
      else if (pick < 23) begin send(rand_stim(c8_pkg::OP_LOAD)); sent++; end
      else begin
        run_word(rand_word(), rand_stim(c8_pkg::OP_EXEC));
        sent += 3;
      end
    end
    in_tvalid <= 1'b0;

    while (results_due.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule

[filelist.f]
rtl/c8_pkg.sv
rtl/chip8_instruction_core.sv
rtl/c8_checker.sv
bench/tb_top.sv
